@@ hdl/brrm_pkg.sv @@
// ----------------------------------------------------------------------------
// brrm_pkg
// Shared types, codes and limits for the two-region sample ring manager.
// ----------------------------------------------------------------------------
package brrm_pkg;

  // Largest ring the manager may be configured for
  localparam int unsigned MAX_SAMPLES = 65536;
  localparam logic [16:0] CAP_LIMIT   =
    (MAX_SAMPLES < 65536) ? 17'(MAX_SAMPLES) : 17'd65536;

  // Command codes
  localparam logic [1:0] CMD_RESERVE = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_SKIP    = 2'd2;
  localparam logic [1:0] CMD_COMMIT  = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_GRANT  = 3'd0;
  localparam logic [2:0] KIND_MOVE   = 3'd1;
  localparam logic [2:0] KIND_SEG    = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [16:0] sample_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] source_offset;
    logic [15:0] target_offset;
    logic [16:0] length;
    logic [16:0] dropped;
    logic [16:0] total_read;
    logic        last;
  } out_item_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DROP,
    S_DISCARD,
    S_PLAN,
    S_MOVE_B,
    S_MOVE_T,
    S_GRANT,
    S_REJECT,
    S_READ_TOP,
    S_READ_BOT,
    S_COMMIT,
    S_DONE
  } state_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DROP,
    OP_DISCARD,
    OP_PLAN,
    OP_EMIT_MOVE_B,
    OP_EMIT_MOVE_T,
    OP_EMIT_GRANT,
    OP_EMIT_REJECT,
    OP_READ_TOP,
    OP_READ_BOT,
    OP_COMMIT,
    OP_EMIT_DONE
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       rejected;
    logic       plan_move_b;
    logic       plan_move_t;
    logic       move_t_pending;
    logic       read_top_emit;
    logic       read_bot_emit;
    logic       slot_free;
  } dp_status_t;

endpackage

@@ hdl/brrm_dp.sv @@
// ----------------------------------------------------------------------------
// brrm_dp
// Region registers, committed count, step arithmetic and the output word
// register of the ring manager.
// ----------------------------------------------------------------------------
module brrm_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata,
  input  brrm_pkg::in_item_t  req,
  input  brrm_pkg::dp_op_t    op,
  output brrm_pkg::dp_status_t status,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output brrm_pkg::out_item_t rsp
);
  import brrm_pkg::*;

  // Ring state
  logic [16:0] cap, cap_next;
  logic [15:0] top_start, top_start_next;
  logic [16:0] top_length, top_length_next;
  logic [15:0] bottom_start, bottom_start_next;
  logic [16:0] bottom_length, bottom_length_next;
  logic [16:0] committed, committed_next;

  // Per-command working registers
  logic [1:0]  cmd_q, cmd_q_next;
  logic [16:0] n_q, n_q_next;
  logic [16:0] drop_q, drop_q_next;
  logic [16:0] total_q, total_q_next;
  logic [15:0] mvb_src, mvb_src_next;
  logic [16:0] mvb_len, mvb_len_next;
  logic        mvt_valid, mvt_valid_next;
  logic [15:0] mvt_src, mvt_src_next;
  logic [15:0] mvt_tgt, mvt_tgt_next;
  logic [16:0] mvt_len, mvt_len_next;
  logic [15:0] grant_q, grant_q_next;

  logic        emit;
  out_item_t   emit_item;
  logic        slot_free;

  // Load clamp for reads
  logic [16:0] ld_n;
  // Room check
  logic [17:0] used;
  logic [17:0] avail;
  logic [16:0] drop_calc;
  logic        rejected;
  // Discard unit
  logic [16:0] amount, d_rem, d_ts17, d_bs17;
  logic [15:0] d_ts, d_bs;
  logic [16:0] d_tl, d_bl, d_comm;
  // Placement plan
  logic [15:0] bs_e;
  logic [17:0] p_end;
  logic [18:0] p_endn;
  logic        p_fit, p_gap_ok;
  logic [16:0] p_tgt;
  logic [15:0] p_ts, p_bs;
  logic [16:0] p_tl, p_bl;
  logic [17:0] p_grant;
  logic        p_mvb, p_mvt;
  // Read segments
  logic [16:0] rt_part, rb_part, r_ts17, r_bs17;
  logic        rt_emit, rb_emit;
  // Commit
  logic [17:0] c_room;
  logic [16:0] c_comm;
  logic [17:0] c_sum;
  // Capacity clamp
  logic [16:0] cfg_cap;

  assign slot_free = !rsp_valid || rsp_ready;

  // Clamp read request to what is committed
  assign ld_n = (req.command == CMD_READ && req.sample_count > committed) ?
                committed : req.sample_count;

  // Work out how much must be dropped for a reserve
  assign used      = {1'b0, top_length} + {1'b0, bottom_length};
  assign avail     = (used >= {1'b0, cap}) ? 18'd0 : {1'b0, cap} - used;
  assign rejected  = n_q > cap;
  assign drop_calc = ({1'b0, n_q} > avail) ? 17'({1'b0, n_q} - avail) : 17'd0;

  // Discard the oldest samples, top region first
  assign amount = (cmd_q == CMD_SKIP) ? n_q : drop_q;
  assign d_comm = (amount >= committed) ? 17'd0 : committed - amount;

  always_comb begin
    d_ts   = top_start;
    d_tl   = top_length;
    d_bs   = bottom_start;
    d_bl   = bottom_length;
    d_rem  = '0;
    d_ts17 = '0;
    d_bs17 = '0;
    if (top_length >= amount) begin
      d_ts17 = {1'b0, top_start} + amount;
      d_ts   = d_ts17[15:0];
      d_tl   = top_length - amount;
    end else begin
      d_rem = amount - top_length;
      d_tl  = '0;
      if (bottom_length >= d_rem) begin
        d_bs17 = {1'b0, bottom_start} + d_rem;
        d_bs   = d_bs17[15:0];
        d_bl   = bottom_length - d_rem;
      end else begin
        d_bl = '0;
      end
    end
    if (d_tl == '0) d_ts = '0;
    if (d_bl == '0) d_bs = '0;
  end

  // Place the reserved range and decide which regions must move
  assign bs_e     = (bottom_length == '0) ? 16'd0 : bottom_start;
  assign p_end    = {2'b0, bs_e} + {1'b0, bottom_length};
  assign p_endn   = {1'b0, p_end} + {2'b0, n_q};
  assign p_fit    = p_endn <= {2'b0, cap};
  assign p_gap_ok = (p_endn <= {3'b0, top_start}) || (n_q == '0);
  assign p_tgt    = (cap >= top_length) ? cap - top_length : 17'd0;

  always_comb begin
    p_ts    = top_start;
    p_tl    = top_length;
    p_bs    = bs_e;
    p_bl    = bottom_length;
    p_grant = p_end;
    p_mvb   = 1'b0;
    p_mvt   = 1'b0;
    if (top_length == '0) begin
      if (p_fit) begin
        p_bl = bottom_length + n_q;
      end else if ({1'b0, bs_e} >= n_q) begin
        p_ts    = bs_e;
        p_tl    = bottom_length;
        p_bs    = '0;
        p_bl    = n_q;
        p_grant = '0;
      end else begin
        p_mvb   = (bottom_length != '0) && (bs_e != '0);
        p_bs    = '0;
        p_grant = {1'b0, bottom_length};
        p_bl    = bottom_length + n_q;
      end
    end else begin
      if (p_gap_ok) begin
        p_bl = bottom_length + n_q;
      end else begin
        p_mvb   = (bottom_length != '0) && (bs_e != '0);
        p_bs    = '0;
        p_mvt   = top_start != p_tgt[15:0];
        p_ts    = p_tgt[15:0];
        p_grant = {1'b0, bottom_length};
        p_bl    = bottom_length + n_q;
      end
    end
    if (p_tl == '0) p_ts = '0;
    if (p_bl == '0) p_bs = '0;
  end

  // Read segment sizes
  assign rt_part = (top_length >= n_q) ? n_q : top_length;
  assign rb_part = (bottom_length >= n_q) ? n_q : bottom_length;
  assign rt_emit = (top_length != '0) && (n_q != '0);
  assign rb_emit = (bottom_length != '0) && (n_q != '0);
  assign r_ts17  = {1'b0, top_start} + rt_part;
  assign r_bs17  = {1'b0, bottom_start} + rb_part;

  // Commit saturates at the stored total
  assign c_room = used - {1'b0, committed};
  assign c_sum  = {1'b0, committed} + {1'b0, n_q};
  assign c_comm = ({1'b0, committed} > used || {1'b0, n_q} >= c_room) ?
                  used[16:0] : c_sum[16:0];

  // Clamp a written capacity into range
  assign cfg_cap = (cfg_wdata == '0) ? 17'd1 :
                   (cfg_wdata > CAP_LIMIT) ? CAP_LIMIT : cfg_wdata;

  // Apply the step chosen by the controller
  always_comb begin
    cap_next           = cap;
    top_start_next     = top_start;
    top_length_next    = top_length;
    bottom_start_next  = bottom_start;
    bottom_length_next = bottom_length;
    committed_next     = committed;
    cmd_q_next         = cmd_q;
    n_q_next           = n_q;
    drop_q_next        = drop_q;
    total_q_next       = total_q;
    mvb_src_next       = mvb_src;
    mvb_len_next       = mvb_len;
    mvt_valid_next     = mvt_valid;
    mvt_src_next       = mvt_src;
    mvt_tgt_next       = mvt_tgt;
    mvt_len_next       = mvt_len;
    grant_q_next       = grant_q;
    emit               = 1'b0;
    emit_item          = '0;

    case (op)
      OP_LOAD: begin
        cmd_q_next   = req.command;
        n_q_next     = ld_n;
        drop_q_next  = '0;
        total_q_next = '0;
        if (req.command == CMD_READ) committed_next = committed - ld_n;
      end
      OP_DROP: begin
        drop_q_next = drop_calc;
      end
      OP_DISCARD: begin
        committed_next     = d_comm;
        top_start_next     = d_ts;
        top_length_next    = d_tl;
        bottom_start_next  = d_bs;
        bottom_length_next = d_bl;
      end
      OP_PLAN: begin
        top_start_next     = p_ts;
        top_length_next    = p_tl;
        bottom_start_next  = p_bs;
        bottom_length_next = p_bl;
        mvb_src_next       = bs_e;
        mvb_len_next       = bottom_length;
        mvt_valid_next     = p_mvt;
        mvt_src_next       = top_start;
        mvt_tgt_next       = p_tgt[15:0];
        mvt_len_next       = top_length;
        grant_q_next       = p_grant[15:0];
      end
      OP_EMIT_MOVE_B: begin
        emit                    = 1'b1;
        emit_item.kind          = KIND_MOVE;
        emit_item.source_offset = mvb_src;
        emit_item.length        = mvb_len;
        emit_item.dropped       = drop_q;
      end
      OP_EMIT_MOVE_T: begin
        emit                    = 1'b1;
        emit_item.kind          = KIND_MOVE;
        emit_item.source_offset = mvt_src;
        emit_item.target_offset = mvt_tgt;
        emit_item.length        = mvt_len;
        emit_item.dropped       = drop_q;
      end
      OP_EMIT_GRANT: begin
        emit                    = 1'b1;
        emit_item.kind          = KIND_GRANT;
        emit_item.target_offset = grant_q;
        emit_item.length        = n_q;
        emit_item.dropped       = drop_q;
        emit_item.last          = 1'b1;
      end
      OP_EMIT_REJECT: begin
        emit           = 1'b1;
        emit_item.kind = KIND_REJECT;
        emit_item.last = 1'b1;
      end
      OP_READ_TOP: begin
        if (rt_emit) begin
          emit                    = 1'b1;
          emit_item.kind          = KIND_SEG;
          emit_item.source_offset = top_start;
          emit_item.length        = rt_part;
          top_length_next         = top_length - rt_part;
          top_start_next          = (top_length == rt_part) ? 16'd0 : r_ts17[15:0];
          n_q_next                = n_q - rt_part;
          total_q_next            = rt_part;
        end
      end
      OP_READ_BOT: begin
        if (rb_emit) begin
          emit                    = 1'b1;
          emit_item.kind          = KIND_SEG;
          emit_item.source_offset = bottom_start;
          emit_item.length        = rb_part;
          bottom_length_next      = bottom_length - rb_part;
          bottom_start_next       = (bottom_length == rb_part) ? 16'd0 : r_bs17[15:0];
          n_q_next                = n_q - rb_part;
          total_q_next            = total_q + rb_part;
        end
      end
      OP_COMMIT: begin
        committed_next = c_comm;
      end
      OP_EMIT_DONE: begin
        emit                 = 1'b1;
        emit_item.kind       = KIND_DONE;
        emit_item.total_read = total_q;
        emit_item.last       = 1'b1;
      end
      default: begin
      end
    endcase

    // A capacity write empties the ring
    if (cfg_we) begin
      cap_next           = cfg_cap;
      top_start_next     = '0;
      top_length_next    = '0;
      bottom_start_next  = '0;
      bottom_length_next = '0;
      committed_next     = '0;
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap           <= CAP_LIMIT;
      top_start     <= '0;
      top_length    <= '0;
      bottom_start  <= '0;
      bottom_length <= '0;
      committed     <= '0;
      mvt_valid     <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      cap           <= cap_next;
      top_start     <= top_start_next;
      top_length    <= top_length_next;
      bottom_start  <= bottom_start_next;
      bottom_length <= bottom_length_next;
      committed     <= committed_next;
      mvt_valid     <= mvt_valid_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_q   <= cmd_q_next;
    n_q     <= n_q_next;
    drop_q  <= drop_q_next;
    total_q <= total_q_next;
    mvb_src <= mvb_src_next;
    mvb_len <= mvb_len_next;
    mvt_src <= mvt_src_next;
    mvt_tgt <= mvt_tgt_next;
    mvt_len <= mvt_len_next;
    grant_q <= grant_q_next;
    if (emit) rsp <= emit_item;
  end

  // Report status to the controller
  always_comb begin
    status.cmd            = cmd_q;
    status.rejected       = rejected;
    status.plan_move_b    = p_mvb;
    status.plan_move_t    = p_mvt;
    status.move_t_pending = mvt_valid;
    status.read_top_emit  = rt_emit;
    status.read_bot_emit  = rb_emit;
    status.slot_free      = slot_free;
  end

endmodule

@@ hdl/brrm_ctrl.sv @@
// ----------------------------------------------------------------------------
// brrm_ctrl
// Command sequencer: steps the datapath through each command and paces
// result words against the output register.
// ----------------------------------------------------------------------------
module brrm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic [1:0]           req_command,
  output logic                 req_ready,
  output brrm_pkg::dp_op_t     op,
  input  brrm_pkg::dp_status_t status
);
  import brrm_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath step
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op = OP_LOAD;
          case (req_command)
            CMD_RESERVE: state_next = S_DROP;
            CMD_READ:    state_next = S_READ_TOP;
            CMD_SKIP:    state_next = S_DISCARD;
            default:     state_next = S_COMMIT;
          endcase
        end
      end
      S_DROP: begin
        op         = OP_DROP;
        state_next = status.rejected ? S_REJECT : S_DISCARD;
      end
      S_DISCARD: begin
        op         = OP_DISCARD;
        state_next = (status.cmd == CMD_RESERVE) ? S_PLAN : S_DONE;
      end
      S_PLAN: begin
        op = OP_PLAN;
        if (status.plan_move_b) begin
          state_next = S_MOVE_B;
        end else if (status.plan_move_t) begin
          state_next = S_MOVE_T;
        end else begin
          state_next = S_GRANT;
        end
      end
      S_MOVE_B: begin
        if (status.slot_free) begin
          op         = OP_EMIT_MOVE_B;
          state_next = status.move_t_pending ? S_MOVE_T : S_GRANT;
        end
      end
      S_MOVE_T: begin
        if (status.slot_free) begin
          op         = OP_EMIT_MOVE_T;
          state_next = S_GRANT;
        end
      end
      S_GRANT: begin
        if (status.slot_free) begin
          op         = OP_EMIT_GRANT;
          state_next = S_IDLE;
        end
      end
      S_REJECT: begin
        if (status.slot_free) begin
          op         = OP_EMIT_REJECT;
          state_next = S_IDLE;
        end
      end
      // Read segment steps wait for the output only when they emit
      S_READ_TOP: begin
        if (status.slot_free || !status.read_top_emit) begin
          op         = OP_READ_TOP;
          state_next = S_READ_BOT;
        end
      end
      S_READ_BOT: begin
        if (status.slot_free || !status.read_bot_emit) begin
          op         = OP_READ_BOT;
          state_next = S_DONE;
        end
      end
      S_COMMIT: begin
        op         = OP_COMMIT;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.slot_free) begin
          op         = OP_EMIT_DONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/bip_ring_region_manager.sv @@
// ----------------------------------------------------------------------------
// bip_ring_region_manager
// Bookkeeping for a two-region sample ring. A command word on req (reserve,
// read, skip, commit) yields one to three result words on rsp: moves, then
// grant for reserve; top segment, bottom segment, done for read; done alone
// for skip and commit. Both channels are valid/ready; the last result word of
// a command has last set. cfg_we with cfg_wdata sets the ring capacity and
// empties the ring; write it only while the block is idle.
// One command at a time. Reserve: drop, discard, plan, then one emit step per
// result word; a rejected reserve goes from drop to its reject word. Read:
// top segment, bottom segment, done. Skip: discard, done. Commit: commit,
// done. The next command is taken once the final word sits in the output
// register. A stalled receiver holds it and the sequencer waits in
// its emit step. Reset empties the ring and sets capacity to its maximum.
// ----------------------------------------------------------------------------
module bip_ring_region_manager (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata,
  input  logic                req_valid,
  output logic                req_ready,
  input  brrm_pkg::in_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output brrm_pkg::out_item_t rsp
);
  import brrm_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  // Sequencer
  brrm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .req_ready   (req_ready),
    .op          (op),
    .status      (status)
  );

  // Region arithmetic and output register
  brrm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .op        (op),
    .status    (status),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

@@ dv/tb_bip_ring_region_manager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bip_ring_region_manager
// Self-checking bench for the two-region sample ring manager. A mirror of the
// ring regions and committed count predicts every descriptor word. A checker
// compares each accepted rsp word field by field against the oldest predicted
// word. Directed tests come first: full ring, zero and oversized reserves,
// saturation, wrap with moves and split reads. Random traffic follows over a
// range of capacities, with bursty requests and a patterned stall on rsp.
// ----------------------------------------------------------------------------
module tb_bip_ring_region_manager;
  import brrm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned REPORT_LIMIT  = 50;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic [16:0] cfg_wdata;
  logic      req_valid;
  logic      req_ready;
  in_item_t  req;
  logic      rsp_valid;
  logic      rsp_ready;
  out_item_t rsp;

  bip_ring_region_manager DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Mirror of the ring bookkeeping
  int unsigned cap_setting;
  int unsigned top_at;
  int unsigned top_len;
  int unsigned bot_at;
  int unsigned bot_len;
  int unsigned ready_count;

  // Descriptor words predicted but not yet seen on rsp
  out_item_t due_words[$];

  int unsigned error_count;
  int unsigned word_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          gaps_on;
  bit          stalls_on;
  logic [15:0] stall_pattern;
  int unsigned stall_pos;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic int unsigned ring_size();
    int unsigned c;
    int unsigned lim;
    c = cap_setting;
    lim = CAP_LIMIT;
    if (c < 1) c = 1;
    if (c > lim) c = lim;
    return c;
  endfunction

  function automatic void clear_mirror();
    top_at = 0;
    top_len = 0;
    bot_at = 0;
    bot_len = 0;
    ready_count = 0;
  endfunction

  function automatic void add_word(input logic [2:0] kind, input int unsigned src,
                                   input int unsigned dst, input int unsigned len,
                                   input int unsigned drop, input int unsigned total,
                                   input bit last);
    out_item_t w;
    w.kind          = kind;
    w.source_offset = 16'(src);
    w.target_offset = 16'(dst);
    w.length        = 17'(len);
    w.dropped       = 17'(drop);
    w.total_read    = 17'(total);
    w.last          = last;
    due_words.push_back(w);
  endfunction

  // Empty regions always start at zero
  function automatic void settle_empty();
    if (top_len == 0) top_at = 0;
    if (bot_len == 0) bot_at = 0;
  endfunction

  function automatic void shrink_ready(input int unsigned n);
    ready_count = (n >= ready_count) ? 0 : ready_count - n;
  endfunction

  // Remove the n oldest samples, top region first
  function automatic void drop_oldest(input int unsigned n);
    int unsigned left;
    left = n;
    if (top_len >= left) begin
      top_at += left;
      top_len -= left;
    end else begin
      left -= top_len;
      top_len = 0;
      if (bot_len >= left) begin
        bot_at += left;
        bot_len -= left;
      end else begin
        bot_len = 0;
      end
    end
    settle_empty();
  endfunction

  function automatic void predict_reserve(input int unsigned n);
    int unsigned cap;
    int unsigned used;
    int unsigned avail;
    int unsigned drop;
    int unsigned grant;
    int unsigned fill_end;
    int unsigned gap;
    int unsigned top_dest;
    cap = ring_size();
    drop = 0;
    if (n > cap) begin
      add_word(KIND_REJECT, 0, 0, 0, 0, 0, 1'b1);
      return;
    end
    // Make room by dropping the oldest samples
    used = top_len + bot_len;
    avail = (used >= cap) ? 0 : cap - used;
    if (avail < n) begin
      drop = n - avail;
      shrink_ready(drop);
      drop_oldest(drop);
    end
    if (bot_len == 0) bot_at = 0;
    fill_end = bot_at + bot_len;
    if (top_len == 0) begin
      if (fill_end <= cap && cap - fill_end >= n) begin
        grant = fill_end;
        bot_len += n;
      end else if (bot_at >= n) begin
        // Old bottom becomes the top, new data starts at zero
        top_at = bot_at;
        top_len = bot_len;
        bot_at = 0;
        bot_len = n;
        grant = 0;
      end else begin
        if (bot_len != 0 && bot_at != 0) add_word(KIND_MOVE, bot_at, 0, bot_len, drop, 0, 1'b0);
        bot_at = 0;
        grant = bot_len;
        bot_len += n;
      end
    end else begin
      gap = (top_at >= fill_end) ? top_at - fill_end : 0;
      if (gap >= n) begin
        grant = fill_end;
        bot_len += n;
      end else begin
        // Compact: bottom to zero, top against the end of the ring
        top_dest = (cap >= top_len) ? cap - top_len : 0;
        if (bot_len != 0 && bot_at != 0) add_word(KIND_MOVE, bot_at, 0, bot_len, drop, 0, 1'b0);
        bot_at = 0;
        if (top_at != top_dest) add_word(KIND_MOVE, top_at, top_dest, top_len, drop, 0, 1'b0);
        top_at = top_dest;
        grant = bot_len;
        bot_len += n;
      end
    end
    settle_empty();
    add_word(KIND_GRANT, 0, grant, n, drop, 0, 1'b1);
  endfunction

  function automatic void predict_read(input int unsigned n);
    int unsigned want;
    int unsigned part;
    int unsigned total;
    want = (n > ready_count) ? ready_count : n;
    ready_count -= want;
    total = 0;
    if (top_len != 0 && want != 0) begin
      part = (top_len >= want) ? want : top_len;
      add_word(KIND_SEG, top_at, 0, part, 0, 0, 1'b0);
      top_at += part;
      top_len -= part;
      want -= part;
      total += part;
    end
    if (bot_len != 0 && want != 0) begin
      part = (bot_len >= want) ? want : bot_len;
      add_word(KIND_SEG, bot_at, 0, part, 0, 0, 1'b0);
      bot_at += part;
      bot_len -= part;
      total += part;
    end
    settle_empty();
    add_word(KIND_DONE, 0, 0, 0, 0, total, 1'b1);
  endfunction

  function automatic void predict_command(input in_item_t w);
    int unsigned n;
    int unsigned stored;
    n = w.sample_count;
    case (w.command)
      CMD_RESERVE: predict_reserve(n);
      CMD_READ:    predict_read(n);
      CMD_SKIP: begin
        shrink_ready(n);
        drop_oldest(n);
        add_word(KIND_DONE, 0, 0, 0, 0, 0, 1'b1);
      end
      default: begin
        // Commit: saturate at what the ring holds
        stored = top_len + bot_len;
        ready_count = (n >= stored - ready_count || ready_count > stored) ?
                      stored : ready_count + n;
        add_word(KIND_DONE, 0, 0, 0, 0, 0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [16:0] got,
                             input logic [16:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s got 0x%0h want 0x%0h",
                                word_count, name, got, want));
  endtask

  always @(posedge clk) begin : check_words
    out_item_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing due, kind %0d",
                                  word_count, rsp.kind));
      end else begin
        want = due_words.pop_front();
        check_field("kind",          17'(rsp.kind),          17'(want.kind));
        check_field("source_offset", 17'(rsp.source_offset), 17'(want.source_offset));
        check_field("target_offset", 17'(rsp.target_offset), 17'(want.target_offset));
        check_field("length",        rsp.length,             want.length);
        check_field("dropped",       rsp.dropped,            want.dropped);
        check_field("total_read",    rsp.total_read,         want.total_read);
        check_field("last",          17'(rsp.last),          17'(want.last));
      end
      word_count++;
    end
  end

  // Receiver: always ready, or with stalls on, a random 16-bit pattern with at least one ready slot
  always @(negedge clk) begin
    if (!stalls_on) begin
      rsp_ready <= 1'b1;
    end else begin
      if (stall_pos == 0) stall_pattern = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
      rsp_ready <= stall_pattern[stall_pos];
      stall_pos = (stall_pos + 1) % 16;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Send one command word; idle between bursts when gaps are enabled
  task automatic send_word(input logic [1:0] cmd, input logic [16:0] cnt);
    in_item_t w;
    w.command = cmd;
    w.sample_count = cnt;
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (req_ready !== 1'b1);
    predict_command(w);
  endtask

  // Hold off requests until every predicted word has come back
  task automatic drain_ring();
    @(negedge clk);
    req_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Capacity write also empties the ring; only done while idle
  task automatic write_capacity(input logic [16:0] value);
    drain_ring();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_setting = value;
    clear_mirror();
  endtask

  function automatic logic [16:0] pick_count();
    int unsigned cap;
    int unsigned r;
    int unsigned span;
    cap = ring_size();
    r = $urandom_range(0, 99);
    span = (cap > 4096) ? cap / 8 : cap;
    if (r < 6) return 17'($urandom_range(0, 131071));
    if (r < 10) return 17'(cap + $urandom_range(0, 1));
    return 17'($urandom_range(0, span));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset capacity: zero, oversized and full reserves, saturation, drop on full
  task automatic test_full_ring_extremes();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_word(CMD_RESERVE, 17'd0);
    send_word(CMD_RESERVE, 17'd65537);
    send_word(CMD_RESERVE, 17'd65536);
    send_word(CMD_COMMIT,  17'h1FFFF);
    send_word(CMD_READ,    17'd1);
    send_word(CMD_RESERVE, 17'd1);
    send_word(CMD_RESERVE, 17'd2);
    send_word(CMD_SKIP,    17'd0);
    send_word(CMD_SKIP,    17'd3);
    send_word(CMD_READ,    17'h1FFFF);
    send_word(CMD_SKIP,    17'h1FFFF);
  endtask

  // Eight-slot ring: wrap, bottom move, top move, gap append, split read
  task automatic test_small_ring_wrap();
    write_capacity(17'd8);
    stalls_on = 1'b1;
    send_word(CMD_RESERVE, 17'd5);
    send_word(CMD_COMMIT,  17'd5);
    send_word(CMD_READ,    17'd3);
    send_word(CMD_RESERVE, 17'd4);
    send_word(CMD_COMMIT,  17'd6);
    send_word(CMD_READ,    17'd4);
    drain_ring();
    send_word(CMD_RESERVE, 17'd3);
    send_word(CMD_RESERVE, 17'd2);
    send_word(CMD_RESERVE, 17'd1);
    send_word(CMD_COMMIT,  17'd100);
    send_word(CMD_READ,    17'd5);
    send_word(CMD_RESERVE, 17'd9);
    send_word(CMD_RESERVE, 17'd8);
    send_word(CMD_SKIP,    17'd2);
  endtask

  // Random commands over a range of capacities and idling modes
  task automatic test_random_traffic();
    logic [16:0] caps[9]  = '{17'd16, 17'd0, 17'd37, 17'd5, 17'h1FFFF,
                              17'd300, 17'd1, 17'd2, 17'd65536};
    int unsigned counts[9] = '{40, 20, 40, 30, 40, 40, 15, 20, 15};
    int unsigned r;
    logic [1:0] cmd;
    for (int p = 0; p < 9; p++) begin
      write_capacity(caps[p]);
      gaps_on   = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      stalls_on = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      for (int i = 0; i < counts[p]; i++) begin
        r = $urandom_range(0, 99);
        if (r < 35) cmd = CMD_RESERVE;
        else if (r < 60) cmd = CMD_COMMIT;
        else if (r < 90) cmd = CMD_READ;
        else cmd = CMD_SKIP;
        send_word(cmd, pick_count());
        if ($urandom_range(0, 29) == 0) drain_ring();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    error_count = 0;
    word_count = 0;
    cycle_count = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    stall_pattern = '0;
    stall_pos = 0;
    cap_setting = 65536;
    clear_mirror();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_full_ring_extremes();
    test_small_ring_wrap();
    test_random_traffic();
    drain_ring();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
